[sv/i2crb_pkg.sv]
// ----------------------------------------------------------------------------
// i2crb_pkg
// Shared types and constants for the I2C slave register bank: transaction
// payloads, bus event codes, command codes and fixed register addresses.
// ----------------------------------------------------------------------------
package i2crb_pkg;

	// Bus event codes carried in the operation field
	localparam logic [2:0] OP_WR_ADDR = 3'd0;
	localparam logic [2:0] OP_RD_ADDR = 3'd1;
	localparam logic [2:0] OP_RX_BYTE = 3'd2;
	localparam logic [2:0] OP_TX_ACK  = 3'd3;

	// Command codes, taken from the pointer's low nibble
	localparam logic [3:0] CMD_RELAY_FIRST = 4'd1;
	localparam logic [3:0] CMD_RELAY_LAST  = 4'd4;
	localparam logic [3:0] CMD_LED_RED     = 4'd8;
	localparam logic [3:0] CMD_LED_GREEN   = 4'd9;

	// Registers kept in flops next to the RAM
	localparam logic [7:0] ACT_LO_REG = 8'd16;
	localparam logic [7:0] ACT_HI_REG = 8'd17;
	localparam logic [7:0] STATUS_REG = 8'h14;

	// Byte sent when the pointer is out of range
	localparam logic [7:0] TX_FILL = 8'hFF;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       ack_next;
		logic [3:0] relay_lines;
		logic       led_red;
		logic       led_green;
	} rsp_t;

	// RAM access issued by the control unit
	typedef struct packed {
		logic       rd;
		logic       wr;
		logic [7:0] ptr;
		logic [7:0] wdata;
	} mem_req_t;

	// Result fields decided at acceptance; tx byte comes from RAM when use_ram
	typedef struct packed {
		logic       use_ram;
		logic [7:0] tx_data;
		logic       tx_valid;
		logic       ack;
		logic [3:0] relay;
		logic       red;
		logic       green;
	} meta_t;

endpackage

[sv/i2crb_ram.sv]
// ----------------------------------------------------------------------------
// i2crb_ram
// Generic single-clock RAM: one write port, one read port, registered read
// that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module i2crb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/i2crb_ctrl.sv]
// ----------------------------------------------------------------------------
// i2crb_ctrl
// Event decoder and control state: pointer, address-phase flag, activity
// counter, mirrored counter and status registers, relay and LED levels.
// Issues the RAM access and the result fields for each accepted event.
// ----------------------------------------------------------------------------
module i2crb_ctrl #(
	parameter int REG_COUNT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  i2crb_pkg::req_t     req,
	output i2crb_pkg::mem_req_t mem_req,
	output i2crb_pkg::meta_t    meta
);

	logic [7:0]  ptr_q, ptr_d;
	logic        phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  r16_q, r16_d;
	logic [7:0]  r17_q, r17_d;
	logic [7:0]  r20_q, r20_d;
	logic [3:0]  relay_q, relay_d;
	logic        red_q, red_d;
	logic        green_q, green_d;

	logic        in_range;
	logic        on;
	logic [3:0]  sel;
	logic [1:0]  rly_idx;

	assign in_range = ({1'b0, ptr_q} < 9'(REG_COUNT));
	assign on       = |req.rx_byte;
	assign sel      = ptr_q[3:0];
	assign rly_idx  = 2'(sel - i2crb_pkg::CMD_RELAY_FIRST);

	// Event decode and next state
	always_comb begin
		ptr_d   = ptr_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		r16_d   = r16_q;
		r17_d   = r17_q;
		r20_d   = r20_q;
		relay_d = relay_q;
		red_d   = red_q;
		green_d = green_q;

		mem_req       = '0;
		mem_req.ptr   = ptr_q;
		mem_req.wdata = req.rx_byte;

		meta          = '0;
		meta.ack      = 1'b1;

		unique case (req.operation)
			i2crb_pkg::OP_WR_ADDR: begin
				cnt_d   = cnt_q + 16'd1;
				r16_d   = cnt_d[7:0];
				r17_d   = cnt_d[15:8];
				phase_d = 1'b0;
			end
			i2crb_pkg::OP_RD_ADDR, i2crb_pkg::OP_TX_ACK: begin
				if (phase_q) begin
					meta.tx_valid = 1'b1;
					ptr_d         = ptr_q + 8'd1;
					if (in_range) begin
						priority if (ptr_q == i2crb_pkg::ACT_LO_REG) begin
							meta.tx_data = r16_q;
						end else if (ptr_q == i2crb_pkg::ACT_HI_REG) begin
							meta.tx_data = r17_q;
						end else if (ptr_q == i2crb_pkg::STATUS_REG) begin
							meta.tx_data = r20_q;
						end else begin
							meta.use_ram = 1'b1;
							mem_req.rd   = acc;
						end
					end else begin
						meta.tx_data = i2crb_pkg::TX_FILL;
						meta.ack     = 1'b0;
					end
				end else begin
					meta.ack = 1'b0;
				end
			end
			i2crb_pkg::OP_RX_BYTE: begin
				if (!phase_q) begin
					// first byte of a write sets the pointer
					ptr_d   = req.rx_byte;
					phase_d = 1'b1;
				end else begin
					ptr_d = ptr_q + 8'd1;
					if (in_range) begin
						priority if (ptr_q == i2crb_pkg::ACT_LO_REG) begin
							r16_d = req.rx_byte;
						end else if (ptr_q == i2crb_pkg::ACT_HI_REG) begin
							r17_d = req.rx_byte;
						end else if (ptr_q == i2crb_pkg::STATUS_REG) begin
							r20_d = req.rx_byte;
						end else begin
							mem_req.wr = acc;
						end
					end else begin
						// command space: low nibble picks the command
						meta.ack = 1'b0;
						priority if (sel >= i2crb_pkg::CMD_RELAY_FIRST &&
							sel <= i2crb_pkg::CMD_RELAY_LAST) begin
							relay_d[rly_idx]         = on;
							r20_d[{1'b0, rly_idx}] = on;
						end else if (sel == i2crb_pkg::CMD_LED_RED) begin
							red_d = on;
						end else if (sel == i2crb_pkg::CMD_LED_GREEN) begin
							green_d = on;
						end else begin
							// unassigned command codes do nothing
						end
					end
				end
			end
			default: begin
			end
		endcase

		meta.relay = relay_d;
		meta.red   = red_d;
		meta.green = green_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			r16_q   <= '0;
			r17_q   <= '0;
			r20_q   <= '0;
			relay_q <= '0;
			red_q   <= 1'b0;
			green_q <= 1'b0;
		end else if (acc) begin
			ptr_q   <= ptr_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			r16_q   <= r16_d;
			r17_q   <= r17_d;
			r20_q   <= r20_d;
			relay_q <= relay_d;
			red_q   <= red_d;
			green_q <= green_d;
		end
	end

endmodule

[sv/i2c_slave_register_bank_top.sv]
// ----------------------------------------------------------------------------
// i2c_slave_register_bank_top
// Each event's result is registered and shown in the cycle after acceptance.
// Throughput: one event per cycle while no stalled result is held; the RAM
// is read or written at most once per event.
// Reset (arst_n, async): clears pointer, flags, counter, relays, LEDs and the
// per-entry valid bits; RAM entries never written read as zero.
// ----------------------------------------------------------------------------
module i2c_slave_register_bank_top #(
	parameter int REG_COUNT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2crb_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2crb_pkg::rsp_t rsp
);

	localparam int AW = $clog2(REG_COUNT);

	logic                 acc;
	i2crb_pkg::mem_req_t  mem_req;
	i2crb_pkg::meta_t     meta;
	i2crb_pkg::meta_t     meta_s1;
	logic                 s1_valid_q;
	logic                 vld_s1;
	logic [REG_COUNT-1:0] vld_q;
	logic [7:0]           ram_rdata;

	// Handshake: a new transaction enters unless a stalled result is held
	assign req_stall = s1_valid_q & rsp_stall;
	assign acc       = req_valid & ~req_stall;

	i2crb_ctrl #(
		.REG_COUNT(REG_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.req     (req),
		.mem_req (mem_req),
		.meta    (meta)
	);

	i2crb_ram #(
		.WIDTH(8),
		.DEPTH(REG_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.wr),
		.waddr (mem_req.ptr[AW-1:0]),
		.wdata (mem_req.wdata),
		.re    (mem_req.rd),
		.raddr (mem_req.ptr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Written-entry flags stand in for clearing the RAM at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_req.wr) begin
			vld_q[mem_req.ptr[AW-1:0]] <= 1'b1;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1 <= meta;
			vld_s1  <= vld_q[mem_req.ptr[AW-1:0]];
		end
	end

	// Output assembly; RAM data holds while the result is stalled
	assign rsp_valid       = s1_valid_q;
	assign rsp.tx_byte     = meta_s1.use_ram ? (vld_s1 ? ram_rdata : 8'h00)
		: meta_s1.tx_data;
	assign rsp.tx_valid    = meta_s1.tx_valid;
	assign rsp.ack_next    = meta_s1.ack;
	assign rsp.relay_lines = meta_s1.relay;
	assign rsp.led_red     = meta_s1.red;
	assign rsp.led_green   = meta_s1.green;

`ifndef SYNTH
	// RAM is touched only by an accepted transaction
	a_mem_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.rd || mem_req.wr) |-> acc)
		else $error("RAM access without an accepted transaction");

	// One port operation per event
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd && mem_req.wr))
		else $error("RAM read and write in the same event");

	// RAM access stays inside the register range
	a_mem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.rd || mem_req.wr) |-> ({1'b0, mem_req.ptr} < 9'(REG_COUNT)))
		else $error("RAM access beyond the register range");

	// A result with no loaded byte carries zero
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.tx_valid) |-> (rsp.tx_byte == 8'h00))
		else $error("tx_byte nonzero without tx_valid");
`endif

endmodule

[tb/sv/tb_i2c_slave_register_bank_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_slave_register_bank_top
// Self-checking bench for the I2C slave register bank. Bus events go in over a
// valid/stall channel. A cycle-free model of the bank predicts each response,
// and the checker compares every response field with the oldest prediction.
// Directed cases cover idle reads, store and fetch at the top of the bank,
// relay and LED commands, pointer wrap and the activity counter mirror. Random
// write and read transactions with noise follow, under three idling profiles.
// ----------------------------------------------------------------------------
module tb_i2c_slave_register_bank_top;

	localparam int NUM_REGS      = 64;
	localparam int NUM_AW        = $clog2(NUM_REGS);
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_EVENTS = 960;
	localparam int MIRROR_BUMPS  = 260;
	localparam int MAX_PRINTED   = 50;

	// Event codes the bank treats as "other"
	localparam logic [2:0] OP_OTHER_LO = 3'd4;
	localparam logic [2:0] OP_OTHER_HI = 3'd7;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	i2crb_pkg::req_t req;
	logic            rsp_valid;
	logic            rsp_stall;
	i2crb_pkg::rsp_t rsp;

	i2c_slave_register_bank_top #(
		.REG_COUNT(NUM_REGS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Bank model state
	logic [7:0]  bank_regs [0:NUM_REGS-1];
	logic [7:0]  bank_ptr;
	logic        bank_addr_done;
	logic [15:0] bank_activity;
	logic [3:0]  bank_relays;
	logic        bank_red;
	logic        bank_green;

	i2crb_pkg::rsp_t due_responses[$];

	int error_count;
	int events_sent;
	int responses_checked;
	int tx_loads;
	int commands_run;
	int cycle_count;
	int snd_idle_pct;
	int rcv_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses pending", cycle_count,
				due_responses.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[cycle %0d] mismatch: %s got 0x%0h want 0x%0h", cycle_count, what,
				got, want);
	endtask

	// Predict the response to one bus event and update the model
	function automatic i2crb_pkg::rsp_t bank_response(input i2crb_pkg::req_t ev);
		i2crb_pkg::rsp_t r;
		logic [3:0]      sel;
		logic [1:0]      bit_idx;
		logic            on;
		r = '0;
		r.ack_next = 1'b1;
		case (ev.operation)
			i2crb_pkg::OP_WR_ADDR: begin
				bank_activity = bank_activity + 16'd1;
				bank_regs[NUM_AW'(i2crb_pkg::ACT_LO_REG)] = bank_activity[7:0];
				bank_regs[NUM_AW'(i2crb_pkg::ACT_HI_REG)] = bank_activity[15:8];
				bank_addr_done = 1'b0;
			end
			i2crb_pkg::OP_RD_ADDR, i2crb_pkg::OP_TX_ACK: begin
				r.ack_next = 1'b0;
				if (bank_addr_done) begin
					if (bank_ptr < NUM_REGS) begin
						r.tx_byte  = bank_regs[bank_ptr[NUM_AW-1:0]];
						r.ack_next = 1'b1;
					end else begin
						r.tx_byte = i2crb_pkg::TX_FILL;
					end
					r.tx_valid = 1'b1;
					bank_ptr = bank_ptr + 8'd1;
					tx_loads++;
				end
			end
			i2crb_pkg::OP_RX_BYTE: begin
				if (!bank_addr_done) begin
					// first byte of a write sets the pointer
					bank_ptr = ev.rx_byte;
					bank_addr_done = 1'b1;
				end else begin
					if (bank_ptr < NUM_REGS) begin
						bank_regs[bank_ptr[NUM_AW-1:0]] = ev.rx_byte;
					end else begin
						// out of range: low nibble picks a command
						sel = bank_ptr[3:0];
						on  = (ev.rx_byte != 8'd0);
						if (sel >= i2crb_pkg::CMD_RELAY_FIRST &&
							sel <= i2crb_pkg::CMD_RELAY_LAST) begin
							bit_idx = 2'(sel - i2crb_pkg::CMD_RELAY_FIRST);
							bank_relays[bit_idx] = on;
							bank_regs[NUM_AW'(i2crb_pkg::STATUS_REG)][{1'b0, bit_idx}] = on;
						end else if (sel == i2crb_pkg::CMD_LED_RED) begin
							bank_red = on;
						end else if (sel == i2crb_pkg::CMD_LED_GREEN) begin
							bank_green = on;
						end
						r.ack_next = 1'b0;
						commands_run++;
					end
					bank_ptr = bank_ptr + 8'd1;
				end
			end
			default: begin
			end
		endcase
		r.relay_lines = bank_relays;
		r.led_red     = bank_red;
		r.led_green   = bank_green;
		return r;
	endfunction

	task automatic check_response();
		i2crb_pkg::rsp_t want;
		if (due_responses.size() == 0) begin
			report_mismatch("response with nothing pending", rsp, 0);
			return;
		end
		want = due_responses.pop_front();
		responses_checked++;
		if (rsp.tx_byte !== want.tx_byte)
			report_mismatch("tx_byte", rsp.tx_byte, want.tx_byte);
		if (rsp.tx_valid !== want.tx_valid)
			report_mismatch("tx_valid", rsp.tx_valid, want.tx_valid);
		if (rsp.ack_next !== want.ack_next)
			report_mismatch("ack_next", rsp.ack_next, want.ack_next);
		if (rsp.relay_lines !== want.relay_lines)
			report_mismatch("relay_lines", rsp.relay_lines, want.relay_lines);
		if (rsp.led_red !== want.led_red)
			report_mismatch("led_red", rsp.led_red, want.led_red);
		if (rsp.led_green !== want.led_green)
			report_mismatch("led_green", rsp.led_green, want.led_green);
	endtask

	// Response side: random stall, check every response as it is taken
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_response();
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
	end

	// Send one bus event; the prediction is queued when it is accepted
	task automatic send_event(input logic [2:0] op, input logic [7:0] data);
		i2crb_pkg::req_t item;
		item.operation = op;
		item.rx_byte   = data;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due_responses.push_back(bank_response(item));
		events_sent++;
	endtask

	// Hold off the request side until every response is back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_responses.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_pointer();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(0, NUM_REGS - 1));
		if (r < 85)
			return 8'($urandom_range(NUM_REGS, NUM_REGS + 15));
		if (r < 95)
			return 8'($urandom_range(248, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 8'h00;
		if (r < 35)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Reads and sent bytes before any write addressing load nothing
	task automatic test_idle_reads();
		send_event(i2crb_pkg::OP_RD_ADDR, 8'hFF);
		send_event(i2crb_pkg::OP_TX_ACK, 8'h00);
	endtask

	// Top register written and read back, then reading off the end
	task automatic test_store_and_fetch();
		send_event(i2crb_pkg::OP_WR_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'(NUM_REGS - 1));
		send_event(i2crb_pkg::OP_RX_BYTE, 8'hFF);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h55);
		send_event(i2crb_pkg::OP_WR_ADDR, 8'hFF);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'(NUM_REGS - 1));
		send_event(i2crb_pkg::OP_RD_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_TX_ACK, 8'h00);
	endtask

	// All four relays, then both LEDs
	task automatic test_commands();
		send_event(i2crb_pkg::OP_WR_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, {4'h4, i2crb_pkg::CMD_RELAY_FIRST});
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h01);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h80);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'hFF);
		send_event(i2crb_pkg::OP_WR_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, {4'h4, i2crb_pkg::CMD_LED_RED});
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h01);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h02);
	endtask

	// Relay status bits show up in the status register
	task automatic test_status_readback();
		send_event(i2crb_pkg::OP_WR_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, i2crb_pkg::STATUS_REG);
		send_event(i2crb_pkg::OP_RD_ADDR, 8'h00);
	endtask

	task automatic test_other_events();
		send_event(OP_OTHER_LO, 8'h00);
		send_event(OP_OTHER_HI, 8'hFF);
	endtask

	// Pointer at 0xFF: command nibble with no effect, then wrap to register 0
	task automatic test_pointer_wrap();
		send_event(i2crb_pkg::OP_WR_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'hFF);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h5A);
		send_event(i2crb_pkg::OP_RX_BYTE, 8'h77);
	endtask

	// Carry the activity counter into its high byte and read both mirror bytes
	task automatic test_counter_mirror();
		repeat (MIRROR_BUMPS)
			send_event(i2crb_pkg::OP_WR_ADDR, 8'($urandom_range(0, 255)));
		send_event(i2crb_pkg::OP_RX_BYTE, i2crb_pkg::ACT_LO_REG);
		send_event(i2crb_pkg::OP_RD_ADDR, 8'h00);
		send_event(i2crb_pkg::OP_TX_ACK, 8'h00);
	endtask

	// Mostly well-formed write and read transfers, some noise
	task automatic test_random_traffic(input int n_events);
		int start;
		int pick;
		int k;
		bit paused;
		start  = events_sent;
		paused = 1'b0;
		while (events_sent - start < n_events) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_event(i2crb_pkg::OP_WR_ADDR, 8'($urandom_range(0, 255)));
				send_event(i2crb_pkg::OP_RX_BYTE, pick_pointer());
				k = $urandom_range(1, 5);
				repeat (k)
					send_event(i2crb_pkg::OP_RX_BYTE, pick_data());
			end else if (pick < 80) begin
				if ($urandom_range(0, 4) != 0) begin
					send_event(i2crb_pkg::OP_WR_ADDR, 8'($urandom_range(0, 255)));
					send_event(i2crb_pkg::OP_RX_BYTE, pick_pointer());
				end
				send_event(i2crb_pkg::OP_RD_ADDR, 8'($urandom_range(0, 255)));
				k = $urandom_range(0, 5);
				repeat (k)
					send_event(i2crb_pkg::OP_TX_ACK, 8'($urandom_range(0, 255)));
			end else begin
				k = $urandom_range(1, 3);
				repeat (k)
					send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			end
			if (!paused && events_sent - start >= n_events / 2) begin
				drain_responses();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		foreach (bank_regs[i])
			bank_regs[i] = 8'h00;
		bank_ptr       = 8'h00;
		bank_addr_done = 1'b0;
		bank_activity  = 16'h0000;
		bank_relays    = 4'h0;
		bank_red       = 1'b0;
		bank_green     = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases with the sender mostly busy, receiver mostly stalled
		snd_idle_pct  = 11;
		rcv_stall_pct = 75;
		test_idle_reads();
		test_store_and_fetch();
		test_commands();
		test_status_readback();
		test_other_events();
		test_pointer_wrap();
		drain_responses();

		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		test_counter_mirror();

		snd_idle_pct  = 11;
		rcv_stall_pct = 75;
		test_random_traffic(RANDOM_EVENTS / 3);
		snd_idle_pct  = 75;
		rcv_stall_pct = 11;
		test_random_traffic(RANDOM_EVENTS / 3);
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		test_random_traffic(RANDOM_EVENTS - 2 * (RANDOM_EVENTS / 3));

		drain_responses();
		repeat (8) @(posedge clk);

		$display("Ran %0d bus events: %0d byte loads, %0d command bytes, %0d responses checked.",
			events_sent, tx_loads, commands_run, responses_checked);
		$display("Activity counter mirror read across its byte carry; %0d mismatches.",
			error_count);
		if (error_count == 0 && due_responses.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[i2c_slave_register_bank_top.f]
sv/i2crb_pkg.sv
sv/i2crb_ram.sv
sv/i2crb_ctrl.sv
sv/i2c_slave_register_bank_top.sv
tb/sv/tb_i2c_slave_register_bank_top.sv
